FILE: rtl/oaief_pkg.sv
// shared types and constants for the ordered array core
`default_nettype none

package oaief_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  // the find scanner looks at this many cells per cycle
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned CHUNK_ENC_W = 3;

  typedef enum logic [KIND_W-1:0] {
    REQ_APPEND   = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_INSERT   = 3'd2,
    REQ_ERASE    = 3'd3,
    REQ_FIND     = 3'd4
  } req_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    CORE_IDLE = 1'b0,
    CORE_SCAN = 1'b1
  } core_state_e;

  // per-cell command for one request
  typedef struct packed {
    logic load_val;
    logic take_lower;
    logic take_upper;
    logic live;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } scan_stat_t;

endpackage

`default_nettype wire

FILE: rtl/oaief_cell.sv
// one list cell: holds an entry, shifts to or from its neighbours, compares for find
`default_nettype none

module oaief_cell (
  input  logic                            clk_i,
  input  oaief_pkg::cell_ctrl_t           ctrl_i,
  input  logic [oaief_pkg::DATA_W-1:0]    value_i,
  input  logic [oaief_pkg::DATA_W-1:0]    lower_i,
  input  logic [oaief_pkg::DATA_W-1:0]    upper_i,
  output logic [oaief_pkg::DATA_W-1:0]    entry_o,
  output logic                            match_o
);

  logic [oaief_pkg::DATA_W-1:0] entry_q;
  logic [oaief_pkg::DATA_W-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_val) begin
      entry_d = value_i;
    end else if (ctrl_i.take_lower) begin
      entry_d = lower_i;
    end else if (ctrl_i.take_upper) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = ctrl_i.live && (entry_q == value_i);

endmodule

`default_nettype wire

FILE: rtl/oaief_scan.sv
// lowest-match scanner: walks the captured match bits one chunk per cycle while step_i is set
`default_nettype none

module oaief_scan #(
  parameter int unsigned NUM_CHUNKS = 8,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  logic                                        step_i,
  input  logic [NUM_CHUNKS*oaief_pkg::CHUNK_W-1:0]    match_i,
  output oaief_pkg::scan_stat_t                       stat_o,
  output logic [IDX_W-1:0]                            idx_o
);

  localparam int unsigned MATCH_W = NUM_CHUNKS * oaief_pkg::CHUNK_W;
  localparam int unsigned CH_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  logic [MATCH_W-1:0]                   match_q, match_d;
  logic [CH_W-1:0]                      chunk_q, chunk_d;
  logic [oaief_pkg::CHUNK_W-1:0]        low;
  logic [oaief_pkg::CHUNK_ENC_W-1:0]    enc;

  always_comb begin
    match_d = match_q;
    chunk_d = chunk_q;
    if (load_i) begin
      match_d = match_i;
      chunk_d = '0;
    end else if (step_i) begin
      match_d = match_q >> oaief_pkg::CHUNK_W;
      chunk_d = chunk_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
    end else begin
      chunk_q <= chunk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
  end

  assign low = match_q[oaief_pkg::CHUNK_W-1:0];

  // lowest set bit wins
  always_comb begin
    enc = '0;
    for (int j = oaief_pkg::CHUNK_W - 1; j >= 0; j--) begin
      if (low[j]) begin
        enc = oaief_pkg::CHUNK_ENC_W'(j);
      end
    end
  end

  assign stat_o.hit  = |low;
  assign stat_o.last = (chunk_q == CH_W'(NUM_CHUNKS - 1));
  assign idx_o       = IDX_W'({chunk_q, enc});

endmodule

`default_nettype wire

FILE: rtl/ordered_array_insert_erase_find_core.sv
// top level: ordered array list built from a chain of shifting cells
`default_nettype none

// Fixed-capacity list of signed 32-bit values held in a row of CAPACITY cells,
// one entry per cell. Append, remove-last, insert and erase finish in the
// cycle they are accepted: every cell loads the new value or its neighbour's
// entry at once and the result is registered on that same edge. Find first
// captures one compare bit per cell at the accept edge, then the scanner walks
// those bits eight cells per cycle and stops at the first match or after the
// last group. One request is in work at a time; a new transfer is taken once
// the previous result has left or leaves in that cycle. Position out of range,
// an unknown kind and remove-last on an empty list give status 1, append or
// insert on a full list give status 2, a failed find gives status 3;
// fill_count always reports the count after the request.
module ordered_array_insert_erase_find_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [oaief_pkg::KIND_W-1:0]        req_type_i,
  input  logic [$clog2(CAPACITY+1)-1:0]       position_i,
  input  logic signed [oaief_pkg::DATA_W-1:0] value_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [oaief_pkg::STATUS_W-1:0]      status_o,
  output logic [$clog2(CAPACITY)-1:0]         found_index_o,
  output logic [$clog2(CAPACITY+1)-1:0]       fill_count_o
);

  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned NUM_CHUNKS = (CAPACITY + oaief_pkg::CHUNK_W - 1) / oaief_pkg::CHUNK_W;
  localparam int unsigned MATCH_W    = NUM_CHUNKS * oaief_pkg::CHUNK_W;

  oaief_pkg::core_state_e state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  oaief_pkg::status_e     status_q, status_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       fill_q, fill_d;

  logic                   in_xfer;
  oaief_pkg::req_kind_e   kind;
  logic                   full;
  logic                   do_append, do_insert, do_erase;
  logic                   scan_load, scan_step;

  oaief_pkg::cell_ctrl_t         ctrl  [CAPACITY];
  logic [oaief_pkg::DATA_W-1:0]  entry [CAPACITY];
  logic [CAPACITY-1:0]           match_vec;
  logic [MATCH_W-1:0]            match_pad;

  oaief_pkg::scan_stat_t  scan_stat;
  logic [IDX_W-1:0]       scan_idx;

  assign in_stall_o = (state_q != oaief_pkg::CORE_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign kind       = oaief_pkg::req_kind_e'(req_type_i);
  assign full       = (count_q == CNT_W'(CAPACITY));

  // shift commands for the cell row
  assign do_append = in_xfer && (kind == oaief_pkg::REQ_APPEND) && !full;
  assign do_insert = in_xfer && (kind == oaief_pkg::REQ_INSERT) && !full
                     && (position_i <= count_q);
  assign do_erase  = in_xfer && (kind == oaief_pkg::REQ_ERASE) && (position_i < count_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [oaief_pkg::DATA_W-1:0] lower;
    logic [oaief_pkg::DATA_W-1:0] upper;

    assign ctrl[i].load_val   = (do_append && (count_q == CNT_W'(i)))
                                || (do_insert && (position_i == CNT_W'(i)));
    assign ctrl[i].take_lower = do_insert && (position_i < CNT_W'(i)) && (CNT_W'(i) <= count_q);
    assign ctrl[i].take_upper = do_erase && (position_i <= CNT_W'(i))
                                && (CNT_W'(i + 1) < count_q);
    assign ctrl[i].live       = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = entry[i+1];
    end

    oaief_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .value_i (value_i),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[i]),
      .match_o (match_vec[i])
    );
  end

  assign match_pad = MATCH_W'(match_vec);

  oaief_scan #(
    .NUM_CHUNKS (NUM_CHUNKS),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .step_i  (scan_step),
    .match_i (match_pad),
    .stat_o  (scan_stat),
    .idx_o   (scan_idx)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    scan_load   = 1'b0;
    scan_step   = 1'b0;

    unique case (state_q)
      oaief_pkg::CORE_IDLE: begin
        if (in_xfer) begin
          out_valid_d = 1'b1;
          idx_d       = '0;
          status_d    = oaief_pkg::ST_DONE;
          unique case (kind)
            oaief_pkg::REQ_APPEND: begin
              if (full) begin
                status_d = oaief_pkg::ST_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            oaief_pkg::REQ_REMOVE: begin
              if (count_q == '0) begin
                status_d = oaief_pkg::ST_IGNORED;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            oaief_pkg::REQ_INSERT: begin
              if (position_i > count_q) begin
                status_d = oaief_pkg::ST_IGNORED;
              end else if (full) begin
                status_d = oaief_pkg::ST_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            oaief_pkg::REQ_ERASE: begin
              if (position_i >= count_q) begin
                status_d = oaief_pkg::ST_IGNORED;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            oaief_pkg::REQ_FIND: begin
              // result comes from the scanner
              out_valid_d = 1'b0;
              scan_load   = 1'b1;
              state_d     = oaief_pkg::CORE_SCAN;
            end
            default: begin
              status_d = oaief_pkg::ST_IGNORED;
            end
          endcase
          fill_d = count_d;
        end
      end
      oaief_pkg::CORE_SCAN: begin
        // output register is free here: the find was only taken with it emptying
        if (scan_stat.hit) begin
          out_valid_d = 1'b1;
          status_d    = oaief_pkg::ST_DONE;
          idx_d       = scan_idx;
          fill_d      = count_q;
          state_d     = oaief_pkg::CORE_IDLE;
        end else if (scan_stat.last) begin
          out_valid_d = 1'b1;
          status_d    = oaief_pkg::ST_NOT_FOUND;
          idx_d       = '0;
          fill_d      = count_q;
          state_d     = oaief_pkg::CORE_IDLE;
        end else begin
          scan_step = 1'b1;
        end
      end
      default: begin
        state_d = oaief_pkg::CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaief_pkg::CORE_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    idx_q    <= idx_d;
    fill_q   <= fill_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = idx_q;
  assign fill_count_o  = fill_q;

endmodule

`default_nettype wire

FILE: test/tb.sv
// self-checking testbench for the ordered array list core
`timescale 1ns / 1ps

localparam int CAPACITY = 64;
localparam int POS_W    = $clog2(CAPACITY + 1);
localparam int IDX_W    = $clog2(CAPACITY);

// kinds the block does not know, answered as ignored
localparam logic [oaief_pkg::KIND_W-1:0] REQ_BAD_FIRST = 3'd5;
localparam logic [oaief_pkg::KIND_W-1:0] REQ_BAD_MID   = 3'd6;
localparam logic [oaief_pkg::KIND_W-1:0] REQ_BAD_LAST  = 3'd7;

typedef struct {
  oaief_pkg::status_e status;
  logic [IDX_W-1:0]   index;
  logic [POS_W-1:0]   fill;
} list_reply_t;

class list_scoreboard;
  logic signed [oaief_pkg::DATA_W-1:0] cells [CAPACITY];
  int                                  fill;
  list_reply_t                         replies [$];
  int                                  errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  task report(string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors++;
  endtask

  // update the list copy for one accepted request and queue its reply
  function void note_request(logic [oaief_pkg::KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                             logic signed [oaief_pkg::DATA_W-1:0] val);
    list_reply_t r;
    int          p;
    p        = int'(pos);
    r.status = oaief_pkg::ST_DONE;
    r.index  = '0;
    case (kind)
      oaief_pkg::REQ_APPEND: begin
        if (fill >= CAPACITY) r.status = oaief_pkg::ST_FULL;
        else begin
          cells[fill] = val;
          fill++;
        end
      end
      oaief_pkg::REQ_REMOVE: begin
        if (fill == 0) r.status = oaief_pkg::ST_IGNORED;
        else fill--;
      end
      oaief_pkg::REQ_INSERT: begin
        // range is tested before the full test
        if (p > fill) r.status = oaief_pkg::ST_IGNORED;
        else if (fill >= CAPACITY) r.status = oaief_pkg::ST_FULL;
        else begin
          for (int i = fill; i > p; i--) cells[i] = cells[i-1];
          cells[p] = val;
          fill++;
        end
      end
      oaief_pkg::REQ_ERASE: begin
        if (p >= fill) r.status = oaief_pkg::ST_IGNORED;
        else begin
          for (int i = p + 1; i < fill; i++) cells[i-1] = cells[i];
          fill--;
        end
      end
      oaief_pkg::REQ_FIND: begin
        r.status = oaief_pkg::ST_NOT_FOUND;
        // walk down so the lowest match wins
        for (int i = fill - 1; i >= 0; i--) begin
          if (cells[i] == val) begin
            r.status = oaief_pkg::ST_DONE;
            r.index  = i[IDX_W-1:0];
          end
        end
      end
      default: r.status = oaief_pkg::ST_IGNORED;
    endcase
    r.fill = fill[POS_W-1:0];
    replies.insert(replies.size(), r);
  endfunction

  task check_result(logic [oaief_pkg::STATUS_W-1:0] st, logic [IDX_W-1:0] idx,
                    logic [POS_W-1:0] cnt);
    list_reply_t exp;
    if (replies.size() == 0) begin
      report($sformatf("result with nothing outstanding: status %0d", st));
      return;
    end
    exp = replies.pop_front();
    if (st !== exp.status)
      report($sformatf("status %0d, expected %0d", st, exp.status));
    if (idx !== exp.index)
      report($sformatf("found_index %0d, expected %0d", idx, exp.index));
    if (cnt !== exp.fill)
      report($sformatf("fill_count %0d, expected %0d", cnt, exp.fill));
  endtask

  task report_leftovers();
    if (replies.size() != 0)
      report($sformatf("%0d results never arrived", replies.size()));
  endtask
endclass

module tb;

  localparam int ITEMS_PER_PHASE = 382;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  logic [oaief_pkg::KIND_W-1:0]        req_type_i  = '0;
  logic [POS_W-1:0]                    position_i  = '0;
  logic signed [oaief_pkg::DATA_W-1:0] value_i     = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [oaief_pkg::STATUS_W-1:0]      status_o;
  logic [IDX_W-1:0]                    found_index_o;
  logic [POS_W-1:0]                    fill_count_o;

  list_scoreboard sb = new();

  int idle_pct    = 0;
  int stall_pct   = 0;
  bit grow        = 1'b1;

  ordered_array_insert_erase_find_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .fill_count_o (fill_count_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stalls at the rate of the current phase
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // sample between edges: these values hold at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(req_type_i, position_i, value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, found_index_o, fill_count_o);
  end

  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  function automatic logic signed [oaief_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $signed(oaief_pkg::DATA_W'($urandom_range(15))) - 8;
      5, 6, 7:       return $urandom;
      default: begin
        case ($urandom_range(3))
          0:       return {1'b1, {(oaief_pkg::DATA_W-1){1'b0}}};
          1:       return {1'b0, {(oaief_pkg::DATA_W-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // one transfer, held until the block takes it
  task automatic send(logic [oaief_pkg::KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                      logic signed [oaief_pkg::DATA_W-1:0] val);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    position_i <= pos;
    value_i    <= val;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // mostly well-formed requests, drifting the list between empty and full
  task automatic random_request();
    int                                  roll;
    int                                  n;
    logic [oaief_pkg::KIND_W-1:0]        kind;
    logic [POS_W-1:0]                    pos;
    logic signed [oaief_pkg::DATA_W-1:0] val;
    n = sb.fill;
    if (grow && n == CAPACITY && $urandom_range(9) < 3) grow = 1'b0;
    else if (!grow && n == 0 && $urandom_range(9) < 3) grow = 1'b1;
    roll = $urandom_range(99);
    pos  = POS_W'($urandom_range(2**POS_W - 1));
    val  = pick_value();
    if (roll < 5) begin
      kind = oaief_pkg::KIND_W'($urandom_range(REQ_BAD_LAST));
    end else if (roll < 30) begin
      kind = oaief_pkg::REQ_FIND;
      if (n > 0 && $urandom_range(9) < 6) val = sb.cells[$urandom_range(n - 1)];
    end else if (roll < (grow ? 80 : 45)) begin
      if ($urandom_range(1)) kind = oaief_pkg::REQ_APPEND;
      else begin
        kind = oaief_pkg::REQ_INSERT;
        pos  = POS_W'($urandom_range(n));
      end
    end else begin
      if ($urandom_range(1)) kind = oaief_pkg::REQ_REMOVE;
      else begin
        kind = oaief_pkg::REQ_ERASE;
        if (n > 0) pos = POS_W'($urandom_range(n - 1));
      end
    end
    send(kind, pos, val);
  endtask

  initial begin
    int wait_cycles;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases, extremes, shifts, duplicates, unknown kinds
    send(oaief_pkg::REQ_REMOVE, '0, '0);
    send(oaief_pkg::REQ_FIND,   '0, '0);
    send(oaief_pkg::REQ_ERASE,  '0, '0);
    send(oaief_pkg::REQ_INSERT, POS_W'(1), 32'sd5);
    send(oaief_pkg::REQ_INSERT, '0, {1'b0, {(oaief_pkg::DATA_W-1){1'b1}}});
    send(oaief_pkg::REQ_APPEND, '0, {1'b1, {(oaief_pkg::DATA_W-1){1'b0}}});
    send(oaief_pkg::REQ_APPEND, '1, '0);
    send(oaief_pkg::REQ_APPEND, '0, '1);
    send(oaief_pkg::REQ_INSERT, '1, '1);
    send(oaief_pkg::REQ_INSERT, POS_W'(2), 32'sd12345);
    send(oaief_pkg::REQ_FIND,   '1, '1);
    send(oaief_pkg::REQ_APPEND, '0, '1);
    send(oaief_pkg::REQ_FIND,   '0, '1);
    send(oaief_pkg::REQ_FIND,   '0, {1'b1, {(oaief_pkg::DATA_W-1){1'b0}}});
    send(oaief_pkg::REQ_FIND,   '0, 32'sd77);
    send(oaief_pkg::REQ_ERASE,  POS_W'(5), '0);
    send(oaief_pkg::REQ_ERASE,  POS_W'(5), '0);
    send(oaief_pkg::REQ_ERASE,  '0, '0);
    send(oaief_pkg::REQ_INSERT, POS_W'(4), -32'sd3);
    send(REQ_BAD_FIRST, '1, '1);
    send(REQ_BAD_MID,   '0, '0);
    send(REQ_BAD_LAST,  '1, '1);
    send(oaief_pkg::REQ_REMOVE, '1, '1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 82; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (ITEMS_PER_PHASE) random_request();
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.replies.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    sb.report_leftovers();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/oaief_pkg.sv
rtl/oaief_cell.sv
rtl/oaief_scan.sv
rtl/ordered_array_insert_erase_find_core.sv
test/tb.sv
